// File: rtl/core/quadrature_encoder_debounce_decoder_top_macros.svh
// Assertion macros for the quadrature encoder decoder checker.
// Depends on nothing; included by the checker file.
`ifndef QUADRATURE_ENCODER_DEBOUNCE_DECODER_TOP_MACROS_SVH
`define QUADRATURE_ENCODER_DEBOUNCE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QEDD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define QEDD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/qedd_pkg.sv
// Shared types and constants of the quadrature encoder decoder.
// Used by qedd_step, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package qedd_pkg;

  // Item kinds
  localparam logic FUNC_FAST = 1'b0;
  localparam logic FUNC_SLOW = 1'b1;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_DEBOUNCE_PERIOD    = 3'd0;
  localparam logic [2:0] REG_EDGE_DELAY         = 3'd1;
  localparam logic [2:0] REG_FAST_DECREMENT     = 3'd2;
  localparam logic [2:0] REG_EDGE_EXPIRED_VALUE = 3'd3;
  localparam logic [2:0] REG_CW_DETENT_STATE    = 3'd4;
  localparam logic [2:0] REG_CCW_DETENT_STATE   = 3'd5;

  // Register reset values
  localparam logic [7:0]        DEBOUNCE_PERIOD_RST    = 8'd3;
  localparam logic [7:0]        EDGE_DELAY_RST         = 8'd10;
  localparam logic [7:0]        FAST_DECREMENT_RST     = 8'd2;
  localparam logic [7:0]        EDGE_EXPIRED_VALUE_RST = 8'd0;
  localparam logic signed [7:0] CW_DETENT_STATE_RST    = 8'sd4;
  localparam logic signed [7:0] CCW_DETENT_STATE_RST   = -8'sd4;

  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_CW   = 2'd1,
    TURN_CCW  = 2'd2
  } turn_t;

  typedef struct packed {
    logic [7:0]        debounce_period;
    logic [7:0]        edge_delay;
    logic [7:0]        fast_decrement;
    logic [7:0]        edge_expired_value;
    logic signed [7:0] cw_detent_state;
    logic signed [7:0] ccw_detent_state;
  } cfg_t;

  // One encoder's stored state
  typedef struct packed {
    logic              stable_a;
    logic              stable_b;
    logic              accepted_a;
    logic              accepted_b;
    logic [7:0]        settle_count_a;
    logic [7:0]        settle_count_b;
    logic [7:0]        edge_timeout;
    logic              fast_timeout;
    logic signed [7:0] step_state;
    logic signed [7:0] last_step_state;
    logic [7:0]        turn_count;
  } enc_state_t;

  localparam enc_state_t ENC_STATE_RST = '{
    stable_a:        1'b0,
    stable_b:        1'b0,
    accepted_a:      1'b0,
    accepted_b:      1'b0,
    settle_count_a:  8'd0,
    settle_count_b:  8'd0,
    edge_timeout:    EDGE_DELAY_RST,
    fast_timeout:    1'b0,
    step_state:      8'sd0,
    last_step_state: 8'sd0,
    turn_count:      8'd0
  };

  // Clockwise successor of the level code {a, b}
  function automatic logic [1:0] cw_next(input logic [1:0] code);
    logic [1:0] res;
    case (code)
      2'd0:    res = 2'd2;
      2'd1:    res = 2'd0;
      2'd2:    res = 2'd3;
      2'd3:    res = 2'd1;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/core/qedd_step.sv
// Next-state logic of one encoder: debounce, step decode, detent and timeout.
// Depends on qedd_pkg.
`timescale 1ns / 1ps

module qedd_step (
  input  qedd_pkg::cfg_t       cfg,
  input  qedd_pkg::enc_state_t cur,
  input  logic                 func,
  input  logic                 line_a,
  input  logic                 line_b,
  output qedd_pkg::enc_state_t nxt,
  output qedd_pkg::turn_t      turn,
  output logic                 missed
);

  logic              ch_a;
  logic              ch_b;
  logic [1:0]        prev_lv;
  logic [1:0]        cur_lv;
  logic signed [7:0] step1;
  logic [7:0]        tmo_dec;
  logic [7:0]        tmo_new;

  always_comb begin
    nxt     = cur;
    turn    = qedd_pkg::TURN_NONE;
    missed  = 1'b0;
    ch_a    = 1'b0;
    ch_b    = 1'b0;
    prev_lv = {cur.accepted_a, cur.accepted_b};
    cur_lv  = 2'd0;
    step1   = cur.step_state;
    tmo_dec = cur.edge_timeout - 8'd1;
    tmo_new = cur.edge_timeout;

    if (func == qedd_pkg::FUNC_FAST) begin
      // Debounce line A: restart the settle count on a change
      if (cur.stable_a != line_a) begin
        nxt.stable_a       = line_a;
        nxt.settle_count_a = cfg.debounce_period;
      end else if (cur.settle_count_a != 8'd0) begin
        nxt.settle_count_a = cur.settle_count_a - 8'd1;
        ch_a = (nxt.settle_count_a == 8'd0) && (cur.accepted_a != cur.stable_a);
      end

      // Debounce line B
      if (cur.stable_b != line_b) begin
        nxt.stable_b       = line_b;
        nxt.settle_count_b = cfg.debounce_period;
      end else if (cur.settle_count_b != 8'd0) begin
        nxt.settle_count_b = cur.settle_count_b - 8'd1;
        ch_b = (nxt.settle_count_b == 8'd0) && (cur.accepted_b != cur.stable_b);
      end

      // Decode the accepted-to-stable transition
      cur_lv = {nxt.stable_a, nxt.stable_b};
      if (ch_a || ch_b) begin
        nxt.edge_timeout = cfg.edge_delay;
        if (cur_lv == qedd_pkg::cw_next(prev_lv)) begin
          step1 = cur.step_state + 8'sd1;
        end else if (prev_lv == qedd_pkg::cw_next(cur_lv)) begin
          step1 = cur.step_state - 8'sd1;
        end else if (cur_lv != prev_lv) begin
          // Both lines moved: follow the prior direction
          missed           = 1'b1;
          nxt.fast_timeout = 1'b1;
          if (cur.last_step_state != 8'sd0 && !cur.last_step_state[7]) begin
            step1 = cur.step_state + 8'sd1;
          end else if (cur.last_step_state[7]) begin
            step1 = cur.step_state - 8'sd1;
          end
        end
        nxt.step_state      = step1;
        nxt.last_step_state = step1;

        // Complete a detent; the clockwise match wins a tie
        if (step1 == cfg.cw_detent_state) begin
          nxt.step_state = 8'sd0;
          nxt.turn_count = cur.turn_count + 8'd1;
          turn           = qedd_pkg::TURN_CW;
        end else if (step1 == cfg.ccw_detent_state) begin
          nxt.step_state = 8'sd0;
          nxt.turn_count = cur.turn_count - 8'd1;
          turn           = qedd_pkg::TURN_CCW;
        end

        if (ch_a) begin
          nxt.accepted_a = nxt.stable_a;
        end
        if (ch_b) begin
          nxt.accepted_b = nxt.stable_b;
        end
      end
    end else if (cur.edge_timeout != 8'd0) begin
      // Count the timeout down, faster after a missed edge
      if (cur.fast_timeout) begin
        tmo_new = (tmo_dec > cfg.fast_decrement) ? (tmo_dec - cfg.fast_decrement) : 8'd0;
      end else begin
        tmo_new = tmo_dec;
      end
      nxt.edge_timeout = tmo_new;
      if (tmo_new == cfg.edge_expired_value) begin
        nxt.fast_timeout = 1'b0;
        nxt.step_state   = 8'sd0;
      end
    end
  end

endmodule

// File: rtl/core/quadrature_encoder_debounce_decoder_top.sv
// Top level of the multi-channel quadrature encoder decoder.
// Depends on qedd_pkg and qedd_step.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one item per transfer. A fast tick
//   (in_func = 0) carries the raw A and B levels of encoder in_channel; a
//   slow tick (in_func = 1) counts that encoder's edge timeout down.
//   Result channel (out_valid / out_stall): exactly one result per item, in
//   item order: the channel, the turn code, the detent count after the item
//   and the missed-edge flag.
//   Throughput is one item per cycle while the receiver does not stall. The
//   input transfer loads the state memory read and the item into the
//   update stage; the update stage then loads its result into the output
//   register, which drives out_valid. Back-to-back items on the same encoder
//   are served by forwarding the last written state.
//   When the receiver stalls, the output register holds its result; one more
//   item may enter and wait in the update stage, then in_stall rises.
//   Reset clears the pipeline, marks every state memory entry unwritten (an
//   unwritten entry reads as the reset state) and loads register defaults.
//   The APB-style port writes registers at byte address 4*i; write only
//   while the block is idle.

module quadrature_encoder_debounce_decoder_top #(
  parameter int NUM_ENCODERS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic        in_channel,
  input  logic        in_line_a,
  input  logic        in_line_b,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_channel_out,
  output logic [1:0]  out_turn,
  output logic [7:0]  out_detent_count,
  output logic        out_missed_edge,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  qedd_pkg::cfg_t cfg_r;

  qedd_pkg::enc_state_t state_mem_r [NUM_ENCODERS];
  qedd_pkg::enc_state_t rdata_r;
  logic [NUM_ENCODERS-1:0] entry_valid_r;

  logic                 s1_valid_r;
  logic                 s1_func_r;
  logic                 s1_chan_r;
  logic                 s1_line_a_r;
  logic                 s1_line_b_r;
  logic                 s1_absent_r;
  logic [IDX_W-1:0]     s1_addr_r;

  logic                 fwd_valid_r;
  logic [IDX_W-1:0]     fwd_addr_r;
  qedd_pkg::enc_state_t fwd_state_r;

  logic                 out_valid_r;
  logic                 out_channel_r;
  logic [1:0]           out_turn_r;
  logic [7:0]           out_count_r;
  logic                 out_missed_r;

  logic                 in_absent;
  logic [IDX_W-1:0]     in_addr;
  logic                 in_acc;
  logic                 out_hold;
  logic                 s1_adv;
  logic                 mem_wr;
  qedd_pkg::enc_state_t s1_cur;
  qedd_pkg::enc_state_t s1_nxt;
  qedd_pkg::turn_t      s1_turn;
  logic                 s1_missed;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_period    <= qedd_pkg::DEBOUNCE_PERIOD_RST;
      cfg_r.edge_delay         <= qedd_pkg::EDGE_DELAY_RST;
      cfg_r.fast_decrement     <= qedd_pkg::FAST_DECREMENT_RST;
      cfg_r.edge_expired_value <= qedd_pkg::EDGE_EXPIRED_VALUE_RST;
      cfg_r.cw_detent_state    <= qedd_pkg::CW_DETENT_STATE_RST;
      cfg_r.ccw_detent_state   <= qedd_pkg::CCW_DETENT_STATE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        qedd_pkg::REG_DEBOUNCE_PERIOD:    cfg_r.debounce_period    <= pwdata[7:0];
        qedd_pkg::REG_EDGE_DELAY:         cfg_r.edge_delay         <= pwdata[7:0];
        qedd_pkg::REG_FAST_DECREMENT:     cfg_r.fast_decrement     <= pwdata[7:0];
        qedd_pkg::REG_EDGE_EXPIRED_VALUE: cfg_r.edge_expired_value <= pwdata[7:0];
        qedd_pkg::REG_CW_DETENT_STATE:    cfg_r.cw_detent_state    <= pwdata[7:0];
        qedd_pkg::REG_CCW_DETENT_STATE:   cfg_r.ccw_detent_state   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      qedd_pkg::REG_DEBOUNCE_PERIOD:    prdata = {24'd0, cfg_r.debounce_period};
      qedd_pkg::REG_EDGE_DELAY:         prdata = {24'd0, cfg_r.edge_delay};
      qedd_pkg::REG_FAST_DECREMENT:     prdata = {24'd0, cfg_r.fast_decrement};
      qedd_pkg::REG_EDGE_EXPIRED_VALUE: prdata = {24'd0, cfg_r.edge_expired_value};
      qedd_pkg::REG_CW_DETENT_STATE:    prdata = {24'd0, cfg_r.cw_detent_state};
      qedd_pkg::REG_CCW_DETENT_STATE:   prdata = {24'd0, cfg_r.ccw_detent_state};
      default:                          prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // Handshake and stage control
  assign in_absent = (int'(in_channel) >= NUM_ENCODERS);
  assign in_addr   = in_absent ? '0 : IDX_W'(in_channel);
  assign out_hold  = out_valid_r && out_stall;
  assign in_stall  = s1_valid_r && out_hold;
  assign in_acc    = in_valid && !in_stall;
  assign s1_adv    = s1_valid_r && !out_hold;
  assign mem_wr    = s1_adv && !s1_absent_r;

  // State memory: read on transfer, write back from the update stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rdata_r <= state_mem_r[in_addr];
    end
    if (mem_wr) begin
      state_mem_r[s1_addr_r] <= s1_nxt;
    end
  end

  // Track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (mem_wr) begin
      entry_valid_r[s1_addr_r] <= 1'b1;
    end
  end

  // Hold the last write for an item that read the same entry alongside it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (mem_wr) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      fwd_addr_r  <= s1_addr_r;
      fwd_state_r <= s1_nxt;
    end
  end

  // Update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r   <= in_func;
      s1_chan_r   <= in_channel;
      s1_line_a_r <= in_line_a;
      s1_line_b_r <= in_line_b;
      s1_absent_r <= in_absent;
      s1_addr_r   <= in_addr;
    end
  end

  // Pick forwarded, stored or reset state
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      s1_cur = fwd_state_r;
    end else if (entry_valid_r[s1_addr_r]) begin
      s1_cur = rdata_r;
    end else begin
      s1_cur = qedd_pkg::ENC_STATE_RST;
    end
  end

  qedd_step u_step (
    .cfg    (cfg_r),
    .cur    (s1_cur),
    .func   (s1_func_r),
    .line_a (s1_line_a_r),
    .line_b (s1_line_b_r),
    .nxt    (s1_nxt),
    .turn   (s1_turn),
    .missed (s1_missed)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_channel_r <= s1_chan_r;
      if (s1_absent_r) begin
        out_turn_r   <= qedd_pkg::TURN_NONE;
        out_count_r  <= 8'd0;
        out_missed_r <= 1'b0;
      end else begin
        out_turn_r   <= s1_turn;
        out_count_r  <= s1_nxt.turn_count;
        out_missed_r <= s1_missed;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel_out  = out_channel_r;
  assign out_turn         = out_turn_r;
  assign out_detent_count = out_count_r;
  assign out_missed_edge  = out_missed_r;

endmodule

// File: rtl/core/qedd_checker.sv
// Port-level checker for the quadrature encoder decoder, with its bind.
// Depends on qedd_pkg, the macro header and the top level's ports.
`timescale 1ns / 1ps
`include "quadrature_encoder_debounce_decoder_top_macros.svh"

module qedd_checker #(
  parameter int NUM_ENCODERS = 2
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_channel_out,
  input logic [1:0] out_turn,
  input logic [7:0] out_detent_count,
  input logic       out_missed_edge
);

  logic        turn_ok;
  logic        absent_res;
  logic        res_empty;
  logic        out_hold;
  logic [11:0] res;

  // Decode the result properties checked below
  assign turn_ok    = (out_turn == qedd_pkg::TURN_NONE) || (out_turn == qedd_pkg::TURN_CW) ||
                      (out_turn == qedd_pkg::TURN_CCW);
  assign absent_res = out_valid && (int'(out_channel_out) >= NUM_ENCODERS);
  assign res_empty  = (out_turn == qedd_pkg::TURN_NONE) && (out_detent_count == 8'd0) &&
                      !out_missed_edge;
  assign out_hold   = out_valid && out_stall;
  assign res        = {out_channel_out, out_turn, out_detent_count, out_missed_edge};

  // Turn code stays in its defined range
  `QEDD_ASSERT_IMP(a_turn_code, clk, rst_n, out_valid, turn_ok, "turn code out of range")

  // A result for an absent encoder carries no turn, count or missed edge
  `QEDD_ASSERT_IMP(a_absent, clk, rst_n, absent_res, res_empty, "absent result not empty")

  // Input stalls only behind a held result
  `QEDD_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_hold, "stall without a held result")

  // A stalled result holds
  `QEDD_ASSERT_NXT(a_hold, clk, rst_n, out_hold, out_valid && $stable(res), "held result moved")

endmodule

bind quadrature_encoder_debounce_decoder_top qedd_checker #(
  .NUM_ENCODERS (NUM_ENCODERS)
) u_qedd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_channel_out  (out_channel_out),
  .out_turn         (out_turn),
  .out_detent_count (out_detent_count),
  .out_missed_edge  (out_missed_edge)
);
